@@ hw/rtl/fbde_pkg.sv @@
`timescale 1ns / 1ps
package fbde_pkg;

  localparam int CHUNK_BYTES_DEF = 4096;
  localparam int INSTR_DEPTH_DEF = 1024;

  localparam int BS_W        = 13;
  localparam int BLOCK_MIN   = 16;
  localparam int BLOCK_MAX   = 4096;
  localparam int BS_RESET    = 64;
  localparam int SAVINGS_MAX = 16383;

  localparam int FUNC_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int OFF_W   = 12;
  localparam int LEN_W   = 13;
  localparam int TOTAL_W = 11;
  localparam int SAV_W   = 14;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic KIND_COPY   = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 3'd0,
    FN_APP_T  = 3'd1,
    FN_APP_R  = 3'd2,
    FN_ENCODE = 3'd3,
    FN_READ   = 3'd4
  } func_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CLEAR, OP_APP_T, OP_APP_R,
    OP_RD_REQ, OP_RD_DATA, OP_RD_NONE,
    OP_E_INIT, OP_M_PRE, OP_M_SUF, OP_HEAD,
    OP_B_INIT, OP_R_NEXT, OP_M_BLK, OP_M_CB, OP_M_CF, OP_R_UPD, OP_B_NEXT,
    OP_EMIT_INS, OP_BACK_INIT, OP_POP_REQ, OP_POP, OP_COPY,
    OP_END0, OP_END1, OP_END2
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_APT, S_APR, S_RD_REQ, S_RD_DATA,
    S_E_CFG, S_E_PRE, S_E_PRE_W, S_E_SUF, S_E_SUF_W, S_E_HEAD,
    S_B_TOP, S_R_TOP, S_R_BLK_W, S_R_BLK_CHK, S_R_CB_W, S_R_CF, S_R_CF_W,
    S_R_UPD, S_B_DONE, S_POP, S_POP_DATA, S_CPY,
    S_END0, S_END1, S_END2, S_RESP
  } state_e;

  typedef enum logic [1:0] {
    MP_IDLE, MP_ADDR, MP_CMP
  } mph_e;

  typedef struct packed {
    op_e  op;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic toff_end;
    logic roff_end;
    logic rlen_eq;
    logic m_done;
    logic k_eq_blen;
    logic found;
    logic unacc_lt_start;
    logic pop_go;
    logic rd_ok;
  } st_t;

endpackage

@@ hw/rtl/fbde_ram.sv @@
`timescale 1ns / 1ps
module fbde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/fbde_match.sv @@
`timescale 1ns / 1ps
module fbde_match
  import fbde_pkg::*;
#(
  parameter int OW = 12,
  parameter int LW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          back_i,
  input  logic [OW-1:0] ta_i,
  input  logic [OW-1:0] ra_i,
  input  logic [LW-1:0] n_i,
  input  logic [7:0]    tdata_i,
  input  logic [7:0]    rdata_i,
  output logic [OW-1:0] taddr_o,
  output logic [OW-1:0] raddr_o,
  output logic          done_o,
  output logic [LW-1:0] k_o
);

  mph_e          ph_q, ph_d;
  logic [LW-1:0] k_q, k_d;
  logic [OW-1:0] ta_q, ra_q;
  logic [LW-1:0] n_q;
  logic          back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= MP_IDLE;
      k_q  <= '0;
    end else begin
      ph_q <= ph_d;
      k_q  <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == MP_IDLE && start_i) begin
      ta_q   <= ta_i;
      ra_q   <= ra_i;
      n_q    <= n_i;
      back_q <= back_i;
    end
  end

  always_comb begin
    ph_d   = ph_q;
    k_d    = k_q;
    done_o = 1'b0;
    case (ph_q)
      MP_IDLE: begin
        if (start_i) begin
          k_d  = '0;
          ph_d = MP_ADDR;
        end
      end
      MP_ADDR: begin
        if (k_q == n_q) begin
          done_o = 1'b1;
          ph_d   = MP_IDLE;
        end else begin
          ph_d = MP_CMP;
        end
      end
      MP_CMP: begin
        if (tdata_i == rdata_i) begin
          k_d  = k_q + 1'b1;
          ph_d = MP_ADDR;
        end else begin
          done_o = 1'b1;
          ph_d   = MP_IDLE;
        end
      end
      default: ph_d = MP_IDLE;
    endcase
  end

  assign taddr_o = back_q ? ta_q - OW'(k_q) : ta_q + OW'(k_q);
  assign raddr_o = back_q ? ra_q - OW'(k_q) : ra_q + OW'(k_q);
  assign k_o     = k_q;

endmodule

@@ hw/rtl/fbde_datapath.sv @@
`timescale 1ns / 1ps
module fbde_datapath
  import fbde_pkg::*;
#(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int INSTR_DEPTH = INSTR_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [BS_W-1:0]    cfg_wdata_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  cmd_t               cmd_i,
  output st_t                st_o,
  output logic [STAT_W-1:0]  status_o,
  output logic               instr_kind_o,
  output logic [OFF_W-1:0]   instr_offset_o,
  output logic [LEN_W-1:0]   instr_length_o,
  output logic [TOTAL_W-1:0] instr_total_o,
  output logic [SAV_W-1:0]   est_savings_o,
  output logic               last_o
);

  localparam int OW = $clog2(CHUNK_BYTES);
  localparam int LW = $clog2(CHUNK_BYTES + 1);
  localparam int PW = ((LW > BS_W) ? LW : BS_W) + 1;
  localparam int AW = $clog2(INSTR_DEPTH);
  localparam int CW = $clog2(INSTR_DEPTH + 1);
  localparam int SW = 2 * LW + 2;
  localparam int EW = 1 + OW + LW;

  // control registers
  logic [BS_W-1:0] cfg_q;
  logic [LW-1:0]   tl_q, tl_d, rl_q, rl_d;
  logic [CW-1:0]   cnt_q, cnt_d, rp_q, rp_d;
  logic [SAV_W-1:0] sav_q, sav_d;

  // working registers
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [BS_W-1:0]   bs_q, bs_d;
  logic [LW-1:0]     pre_q, pre_d, suf_q, suf_d, unacc_q, unacc_d, es_q, es_d;
  logic [PW-1:0]     toff_q, toff_d, roff_q, roff_d;
  logic [LW-1:0]     blen_q, blen_d, cb_q, cb_d, best_b_q, best_b_d;
  logic [LW-1:0]     best_f_q, best_f_d, best_off_q, best_off_d, back_q, back_d;
  logic              found_q, found_d;
  logic [SW-1:0]     saved_q, saved_d;
  logic [STAT_W-1:0] rs_q, rs_d;
  logic              rk_q, rk_d, rlast_q, rlast_d;
  logic [OW-1:0]     roff_res_q, roff_res_d;
  logic [LW-1:0]     rlen_q, rlen_d;

  // output word
  logic [STAT_W-1:0] o_st_q;
  logic              o_kind_q, o_last_q;
  logic [OW-1:0]     o_off_q;
  logic [LW-1:0]     o_len_q;
  logic [CW-1:0]     o_cnt_q;
  logic [SAV_W-1:0]  o_sav_q;

  // memories
  logic          t_we, r_we, i_we;
  logic [OW-1:0] t_raddr, r_raddr;
  logic [7:0]    t_rdata, r_rdata;
  logic [AW-1:0] i_waddr, i_raddr;
  logic [EW-1:0] i_wdata, i_rdata;

  // match unit
  logic          m_start, m_back, m_done;
  logic [OW-1:0] m_ta, m_ra;
  logic [LW-1:0] m_n, mk;

  fbde_ram #(.WIDTH(8), .DEPTH(CHUNK_BYTES)) u_tram (
    .clk_i, .we_i(t_we), .waddr_i(tl_q[OW-1:0]), .wdata_i(byte_q),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  fbde_ram #(.WIDTH(8), .DEPTH(CHUNK_BYTES)) u_rram (
    .clk_i, .we_i(r_we), .waddr_i(rl_q[OW-1:0]), .wdata_i(byte_q),
    .raddr_i(r_raddr), .rdata_o(r_rdata)
  );

  fbde_ram #(.WIDTH(EW), .DEPTH(INSTR_DEPTH)) u_iram (
    .clk_i, .we_i(i_we), .waddr_i(i_waddr), .wdata_i(i_wdata),
    .raddr_i(i_raddr), .rdata_o(i_rdata)
  );

  fbde_match #(.OW(OW), .LW(LW)) u_match (
    .clk_i, .rst_ni, .start_i(m_start), .back_i(m_back), .ta_i(m_ta), .ra_i(m_ra),
    .n_i(m_n), .tdata_i(t_rdata), .rdata_i(r_rdata), .taddr_o(t_raddr),
    .raddr_o(r_raddr), .done_o(m_done), .k_o(mk)
  );

  // derived values
  logic [PW-1:0]   tl_p, rl_p, bs_p, blen_p, tl_rem, rl_rem, blen_w, rlen_w, tf, rf;
  logic [LW-1:0]   mn_tr, cbn, cfn, start_w, csize, el, take;
  logic [LW:0]     sum_new, sum_best;
  logic            cnt_full;
  logic            ent_kind;
  logic [OW-1:0]   ent_off;
  logic [LW-1:0]   ent_len;
  logic            emit_en, emit_kind;
  logic [OW-1:0]   emit_off;
  logic [LW-1:0]   emit_len;
  logic            pop_wr;
  logic [SW-1:0]   sat_max;

  always_comb begin
    tl_p     = PW'(tl_q);
    rl_p     = PW'(rl_q);
    bs_p     = PW'(bs_q);
    blen_p   = PW'(blen_q);
    mn_tr    = (tl_q < rl_q) ? tl_q : rl_q;
    tl_rem   = tl_p - toff_q;
    rl_rem   = rl_p - roff_q;
    blen_w   = (tl_rem < bs_p) ? tl_rem : bs_p;
    rlen_w   = (rl_rem < bs_p) ? rl_rem : bs_p;
    cbn      = LW'((toff_q < roff_q) ? toff_q : roff_q);
    tf       = tl_rem - blen_p;
    rf       = rl_rem - blen_p;
    cfn      = LW'((tf < rf) ? tf : rf);
    sum_new  = (LW+1)'(cb_q) + (LW+1)'(mk);
    sum_best = (LW+1)'(best_b_q) + (LW+1)'(best_f_q);
    start_w  = LW'(toff_q) - best_b_q;
    csize    = best_b_q + blen_q + best_f_q;
    el       = tl_q - es_q;
    cnt_full = cnt_q >= CW'(INSTR_DEPTH);
    ent_kind = i_rdata[EW-1];
    ent_off  = i_rdata[LW +: OW];
    ent_len  = i_rdata[LW-1:0];
    take     = (back_q < ent_len) ? back_q : ent_len;
    sat_max  = SW'(SAVINGS_MAX);
  end

  assign st_o.toff_end       = toff_q >= tl_p;
  assign st_o.roff_end       = roff_q >= rl_p;
  assign st_o.rlen_eq        = rlen_w == blen_p;
  assign st_o.m_done         = m_done;
  assign st_o.k_eq_blen      = mk == blen_q;
  assign st_o.found          = found_q;
  assign st_o.unacc_lt_start = unacc_q < start_w;
  assign st_o.pop_go         = (back_q != '0) && (cnt_q != '0);
  assign st_o.rd_ok          = rp_q < cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= BS_W'(BS_RESET);
      tl_q  <= '0;
      rl_q  <= '0;
      cnt_q <= '0;
      rp_q  <= '0;
      sav_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      tl_q  <= tl_d;
      rl_q  <= rl_d;
      cnt_q <= cnt_d;
      rp_q  <= rp_d;
      sav_q <= sav_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    bs_q       <= bs_d;
    pre_q      <= pre_d;
    suf_q      <= suf_d;
    unacc_q    <= unacc_d;
    es_q       <= es_d;
    toff_q     <= toff_d;
    roff_q     <= roff_d;
    blen_q     <= blen_d;
    cb_q       <= cb_d;
    best_b_q   <= best_b_d;
    best_f_q   <= best_f_d;
    best_off_q <= best_off_d;
    back_q     <= back_d;
    found_q    <= found_d;
    saved_q    <= saved_d;
    rs_q       <= rs_d;
    rk_q       <= rk_d;
    rlast_q    <= rlast_d;
    roff_res_q <= roff_res_d;
    rlen_q     <= rlen_d;
    if (cmd_i.ld_out) begin
      o_st_q   <= rs_q;
      o_kind_q <= rk_q;
      o_off_q  <= roff_res_q;
      o_len_q  <= rlen_q;
      o_last_q <= rlast_q;
      o_cnt_q  <= cnt_q;
      o_sav_q  <= sav_q;
    end
  end

  always_comb begin
    tl_d = tl_q;  rl_d = rl_q;  cnt_d = cnt_q;  rp_d = rp_q;  sav_d = sav_q;
    byte_d = byte_q;  bs_d = bs_q;  pre_d = pre_q;  suf_d = suf_q;
    unacc_d = unacc_q;  es_d = es_q;  toff_d = toff_q;  roff_d = roff_q;
    blen_d = blen_q;  cb_d = cb_q;  best_b_d = best_b_q;  best_f_d = best_f_q;
    best_off_d = best_off_q;  back_d = back_q;  found_d = found_q;
    saved_d = saved_q;  rs_d = rs_q;  rk_d = rk_q;  rlast_d = rlast_q;
    roff_res_d = roff_res_q;  rlen_d = rlen_q;
    t_we = 1'b0;  r_we = 1'b0;
    m_start = 1'b0;  m_back = 1'b0;  m_ta = '0;  m_ra = '0;  m_n = '0;
    emit_en = 1'b0;  emit_kind = KIND_COPY;  emit_off = '0;  emit_len = '0;
    pop_wr = 1'b0;
    i_raddr = rp_q[AW-1:0];

    case (cmd_i.op)
      OP_ACCEPT: begin
        byte_d = data_byte_i;
        rs_d = ST_OK;  rk_d = 1'b0;  rlast_d = 1'b0;  roff_res_d = '0;  rlen_d = '0;
      end
      OP_CLEAR: begin
        tl_d = '0;  rl_d = '0;  cnt_d = '0;  rp_d = '0;  sav_d = '0;
      end
      OP_APP_T: begin
        if (tl_q < LW'(CHUNK_BYTES)) begin
          t_we = 1'b1;
          tl_d = tl_q + 1'b1;
        end else begin
          rs_d = ST_FULL;
        end
      end
      OP_APP_R: begin
        if (rl_q < LW'(CHUNK_BYTES)) begin
          r_we = 1'b1;
          rl_d = rl_q + 1'b1;
        end else begin
          rs_d = ST_FULL;
        end
      end
      OP_RD_REQ: i_raddr = rp_q[AW-1:0];
      OP_RD_DATA: begin
        rk_d       = ent_kind;
        roff_res_d = ent_off;
        rlen_d     = ent_len;
        rlast_d    = (rp_q + 1'b1) == cnt_q;
        rp_d       = rp_q + 1'b1;
      end
      OP_RD_NONE: rs_d = ST_EMPTY;
      OP_E_INIT: begin
        if (cfg_q < BS_W'(BLOCK_MIN)) begin
          bs_d = BS_W'(BLOCK_MIN);
        end else if (cfg_q > BS_W'(BLOCK_MAX)) begin
          bs_d = BS_W'(BLOCK_MAX);
        end else begin
          bs_d = cfg_q;
        end
        cnt_d = '0;
      end
      OP_M_PRE: begin
        m_start = 1'b1;
        m_n     = mn_tr;
      end
      OP_M_SUF: begin
        pre_d   = mk;
        m_start = 1'b1;
        m_back  = 1'b1;
        m_ta    = OW'(tl_q - 1'b1);
        m_ra    = OW'(rl_q - 1'b1);
        m_n     = mn_tr;
      end
      OP_HEAD: begin
        suf_d   = mk;
        saved_d = SW'(pre_q) + SW'(mk);
        unacc_d = pre_q;
        toff_d  = '0;
        emit_en = pre_q != '0;
        emit_len = pre_q;
      end
      OP_B_INIT: begin
        blen_d = LW'(blen_w);
        roff_d = '0;  found_d = 1'b0;
        best_b_d = '0;  best_f_d = '0;  best_off_d = '0;
      end
      OP_R_NEXT: roff_d = roff_q + bs_p;
      OP_M_BLK: begin
        m_start = 1'b1;
        m_ta    = OW'(toff_q);
        m_ra    = OW'(roff_q);
        m_n     = blen_q;
      end
      OP_M_CB: begin
        found_d = 1'b1;
        m_start = 1'b1;
        m_back  = 1'b1;
        m_ta    = OW'(toff_q - 1'b1);
        m_ra    = OW'(roff_q - 1'b1);
        m_n     = cbn;
      end
      OP_M_CF: begin
        cb_d    = mk;
        m_start = 1'b1;
        m_ta    = OW'(toff_q + blen_p);
        m_ra    = OW'(roff_q + blen_p);
        m_n     = cfn;
      end
      OP_R_UPD: begin
        if (sum_new >= sum_best) begin
          best_b_d   = cb_q;
          best_f_d   = mk;
          best_off_d = LW'(roff_q);
        end
        roff_d = roff_q + bs_p;
      end
      OP_B_NEXT: toff_d = toff_q + bs_p;
      OP_EMIT_INS: begin
        emit_en   = 1'b1;
        emit_kind = KIND_INSERT;
        emit_off  = OW'(unacc_q);
        emit_len  = start_w - unacc_q;
      end
      OP_BACK_INIT: back_d = unacc_q - start_w;
      OP_POP_REQ: i_raddr = AW'(cnt_q - 1'b1);
      OP_POP: begin
        if (ent_kind == KIND_COPY) begin
          saved_d = (saved_q >= SW'(take)) ? saved_q - SW'(take) : '0;
        end
        if (ent_len <= back_q) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          pop_wr = 1'b1;
        end
        back_d = back_q - take;
      end
      OP_COPY: begin
        emit_en  = 1'b1;
        emit_off = OW'(best_off_q - best_b_q);
        emit_len = csize;
        saved_d  = saved_q + SW'(csize);
        unacc_d  = LW'(toff_q) + blen_q + best_f_q;
        toff_d   = toff_q + bs_p;
      end
      OP_END0: es_d = ((tl_q - suf_q) > unacc_q) ? tl_q - suf_q : unacc_q;
      OP_END1: begin
        emit_en   = unacc_q < es_q;
        emit_kind = KIND_INSERT;
        emit_off  = OW'(unacc_q);
        emit_len  = es_q - unacc_q;
      end
      OP_END2: begin
        emit_en  = el != '0;
        emit_off = OW'(rl_q - el);
        emit_len = el;
        sav_d    = (saved_q > sat_max) ? SAV_W'(SAVINGS_MAX) : SAV_W'(saved_q);
        rp_d     = '0;
      end
      default: ;
    endcase

    i_we    = 1'b0;
    i_waddr = cnt_q[AW-1:0];
    i_wdata = {emit_kind, emit_off, emit_len};
    if (pop_wr) begin
      i_we    = 1'b1;
      i_waddr = AW'(cnt_q - 1'b1);
      i_wdata = {ent_kind, ent_off, ent_len - back_q};
    end else if (emit_en && !cnt_full) begin
      i_we  = 1'b1;
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign status_o       = o_st_q;
  assign instr_kind_o   = o_kind_q;
  assign instr_offset_o = OFF_W'(o_off_q);
  assign instr_length_o = LEN_W'(o_len_q);
  assign instr_total_o  = TOTAL_W'(o_cnt_q);
  assign est_savings_o  = o_sav_q;
  assign last_o         = o_last_q;

endmodule

@@ hw/rtl/fbde_ctrl.sv @@
`timescale 1ns / 1ps
module fbde_ctrl
  import fbde_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  st_t               st_i,
  output cmd_t              cmd_o
);

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.ld_out = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          case (func_i)
            FN_CLEAR:  state_d = S_CLR;
            FN_APP_T:  state_d = S_APT;
            FN_APP_R:  state_d = S_APR;
            FN_ENCODE: state_d = S_E_CFG;
            FN_READ:   state_d = S_RD_REQ;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_CLR: begin cmd_o.op = OP_CLEAR; state_d = S_RESP; end
      S_APT: begin cmd_o.op = OP_APP_T; state_d = S_RESP; end
      S_APR: begin cmd_o.op = OP_APP_R; state_d = S_RESP; end
      S_RD_REQ: begin
        if (st_i.rd_ok) begin
          cmd_o.op = OP_RD_REQ;
          state_d  = S_RD_DATA;
        end else begin
          cmd_o.op = OP_RD_NONE;
          state_d  = S_RESP;
        end
      end
      S_RD_DATA: begin cmd_o.op = OP_RD_DATA; state_d = S_RESP; end
      S_E_CFG:   begin cmd_o.op = OP_E_INIT; state_d = S_E_PRE; end
      S_E_PRE:   begin cmd_o.op = OP_M_PRE; state_d = S_E_PRE_W; end
      S_E_PRE_W: if (st_i.m_done) state_d = S_E_SUF;
      S_E_SUF:   begin cmd_o.op = OP_M_SUF; state_d = S_E_SUF_W; end
      S_E_SUF_W: if (st_i.m_done) state_d = S_E_HEAD;
      S_E_HEAD:  begin cmd_o.op = OP_HEAD; state_d = S_B_TOP; end
      S_B_TOP: begin
        if (st_i.toff_end) begin
          state_d = S_END0;
        end else begin
          cmd_o.op = OP_B_INIT;
          state_d  = S_R_TOP;
        end
      end
      S_R_TOP: begin
        if (st_i.roff_end) begin
          state_d = S_B_DONE;
        end else if (!st_i.rlen_eq) begin
          cmd_o.op = OP_R_NEXT;
        end else begin
          cmd_o.op = OP_M_BLK;
          state_d  = S_R_BLK_W;
        end
      end
      S_R_BLK_W: if (st_i.m_done) state_d = S_R_BLK_CHK;
      S_R_BLK_CHK: begin
        if (st_i.k_eq_blen) begin
          cmd_o.op = OP_M_CB;
          state_d  = S_R_CB_W;
        end else begin
          cmd_o.op = OP_R_NEXT;
          state_d  = S_R_TOP;
        end
      end
      S_R_CB_W: if (st_i.m_done) state_d = S_R_CF;
      S_R_CF:   begin cmd_o.op = OP_M_CF; state_d = S_R_CF_W; end
      S_R_CF_W: if (st_i.m_done) state_d = S_R_UPD;
      S_R_UPD:  begin cmd_o.op = OP_R_UPD; state_d = S_R_TOP; end
      S_B_DONE: begin
        if (!st_i.found) begin
          cmd_o.op = OP_B_NEXT;
          state_d  = S_B_TOP;
        end else if (st_i.unacc_lt_start) begin
          cmd_o.op = OP_EMIT_INS;
          state_d  = S_CPY;
        end else begin
          cmd_o.op = OP_BACK_INIT;
          state_d  = S_POP;
        end
      end
      S_POP: begin
        if (st_i.pop_go) begin
          cmd_o.op = OP_POP_REQ;
          state_d  = S_POP_DATA;
        end else begin
          state_d = S_CPY;
        end
      end
      S_POP_DATA: begin cmd_o.op = OP_POP; state_d = S_POP; end
      S_CPY:  begin cmd_o.op = OP_COPY; state_d = S_B_TOP; end
      S_END0: begin cmd_o.op = OP_END0; state_d = S_END1; end
      S_END1: begin cmd_o.op = OP_END1; state_d = S_END2; end
      S_END2: begin cmd_o.op = OP_END2; state_d = S_RESP; end
      S_RESP: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (cmd_o.ld_out) begin
      ov_d = 1'b1;
    end
  end

  assign out_valid_o = ov_q;

endmodule

@@ hw/rtl/fixed_block_delta_encoder.sv @@
`timescale 1ns / 1ps
// Fixed-block delta encoder.
// Input channel (in_valid_i/in_ready_o) carries one command word: func_i and
// data_byte_i. Every command returns exactly one word on the output channel
// (out_valid_o/out_ready_i) with status, one instruction, the instruction
// count and the estimated saving of the last encode.
// Clear, append and read each pass through their own work states before the
// response state; an unused code goes straight to it. Encode walks both
// byte stores through one compare unit; its time grows with the number of
// target blocks times reference blocks, the lengths of their extensions,
// the number of popped instructions and the number of blocks.
// One command is in work at a time; in_ready_o is high in the idle state,
// also while an earlier output word waits; the next command is then carried
// out and its result waits in the response state until the output register
// is free. A stalled receiver holds the output word and stalls the block
// after one further command.
// block_size must be written through cfg_we_i/cfg_wdata_i only while idle;
// the block does not enforce it. Reset empties both stores, the instruction
// list and saving; block_size returns to 64. Store contents are not cleared.
module fixed_block_delta_encoder
  import fbde_pkg::*;
#(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int INSTR_DEPTH = INSTR_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [BS_W-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [STAT_W-1:0]  status_o,
  output logic               instr_kind_o,
  output logic [OFF_W-1:0]   instr_offset_o,
  output logic [LEN_W-1:0]   instr_length_o,
  output logic [TOTAL_W-1:0] instr_total_o,
  output logic [SAV_W-1:0]   est_savings_o,
  output logic               last_o
);

  cmd_t cmd;
  st_t  st;

  fbde_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i,
    .out_valid_o, .out_ready_i, .st_i(st), .cmd_o(cmd)
  );

  fbde_datapath #(
    .CHUNK_BYTES(CHUNK_BYTES),
    .INSTR_DEPTH(INSTR_DEPTH)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .data_byte_i,
    .cmd_i(cmd), .st_o(st), .status_o, .instr_kind_o, .instr_offset_o,
    .instr_length_o, .instr_total_o, .est_savings_o, .last_o
  );

endmodule

@@ hw/rtl/fbde_checker.sv @@
`timescale 1ns / 1ps
module fbde_checker
  import fbde_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [STAT_W-1:0]  status_o,
  input logic               instr_kind_o,
  input logic [LEN_W-1:0]   instr_length_o,
  input logic               last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(last_o))
    else $error("output word dropped while stalled");

  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> status_o == ST_OK)
    else $error("last flag on a failed word");

  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_EMPTY)
      |-> !instr_kind_o && instr_length_o == '0 && !last_o)
    else $error("instruction fields set on a failed word");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_FULL || status_o == ST_EMPTY)
    else $error("undefined status code");

endmodule

bind fixed_block_delta_encoder fbde_checker u_chk (.*);

@@ tb/sv/tb_fixed_block_delta_encoder.sv @@
`timescale 1ns / 1ps
module tb_fixed_block_delta_encoder;
  import fbde_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
  localparam int CHUNK     = CHUNK_BYTES_DEF;
  localparam int RAND_WORDS = 1850;
  localparam int IDLE_LIMIT = 400000;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               kind;
    logic [OFF_W-1:0]   offset;
    logic [LEN_W-1:0]   length;
    logic [TOTAL_W-1:0] total;
    logic [SAV_W-1:0]   savings;
    logic               last;
  } resp_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data;
    logic              typed;
    resp_t             want;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [BS_W-1:0]    cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FUNC_W-1:0]  func = '0;
  logic [BYTE_W-1:0]  data_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STAT_W-1:0]  status;
  logic               instr_kind;
  logic [OFF_W-1:0]   instr_offset;
  logic [LEN_W-1:0]   instr_length;
  logic [TOTAL_W-1:0] instr_total;
  logic [SAV_W-1:0]   est_savings;
  logic               last;

  fixed_block_delta_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .instr_kind_o  (instr_kind),
    .instr_offset_o(instr_offset),
    .instr_length_o(instr_length),
    .instr_total_o (instr_total),
    .est_savings_o (est_savings),
    .last_o        (last)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [7:0]         tgt_mem [CHUNK];
  logic [7:0]         base_mem [CHUNK];
  int unsigned        tgt_len, base_len;
  logic               ins_kind [INSTR_DEPTH_DEF];
  int unsigned        ins_off [INSTR_DEPTH_DEF];
  int unsigned        ins_len [INSTR_DEPTH_DEF];
  int unsigned        ins_cnt, rd_ptr, sav_total;
  logic [BS_W-1:0]    blk_size_reg = BS_W'(BS_RESET);

  resp_t pending_words [$];
  int    err_cnt = 0;
  int    n_sent = 0;
  int    n_checked = 0;
  int    n_encodes = 0;
  int    n_copies = 0;
  bit    in_burst = 1'b0;
  bit    out_burst = 1'b0;
  int    idle_cyc = 0;

  function automatic int unsigned lead_len(int unsigned ta, int unsigned na,
                                           int unsigned rb, int unsigned nb);
    int unsigned n, k;
    n = (na < nb) ? na : nb;
    k = 0;
    while (k < n && tgt_mem[ta+k] == base_mem[rb+k]) k++;
    return k;
  endfunction

  function automatic int unsigned tail_len(int unsigned na, int unsigned nb);
    int unsigned n, k;
    n = (na < nb) ? na : nb;
    k = 0;
    while (k < n && tgt_mem[na-1-k] == base_mem[nb-1-k]) k++;
    return k;
  endfunction

  function automatic void push_instr(logic kind, int unsigned off, int unsigned len);
    if (ins_cnt >= INSTR_DEPTH_DEF) return;
    ins_kind[ins_cnt] = kind;
    ins_off[ins_cnt]  = off;
    ins_len[ins_cnt]  = len;
    ins_cnt++;
  endfunction

  function automatic void run_encode();
    int unsigned bs, tl, rl, pre, suf, unacc, toff, roff, blen, rblen;
    int unsigned cb, cf, best_b, best_f, best_off, start, back, i, sz, take;
    int unsigned csize, end_start, end_len, k;
    longint unsigned saved;
    bit found, same;
    bs = blk_size_reg;
    if (bs < BLOCK_MIN) bs = BLOCK_MIN;
    if (bs > BLOCK_MAX) bs = BLOCK_MAX;
    tl = tgt_len;
    rl = base_len;
    pre = lead_len(0, tl, 0, rl);
    suf = tail_len(tl, rl);
    saved = pre + suf;
    ins_cnt = 0;
    if (pre != 0) push_instr(KIND_COPY, 0, pre);
    unacc = pre;
    for (toff = 0; toff < tl; toff += bs) begin
      blen = (tl - toff < bs) ? tl - toff : bs;
      found = 0;
      best_b = 0;
      best_f = 0;
      best_off = 0;
      for (roff = 0; roff < rl; roff += bs) begin
        rblen = (rl - roff < bs) ? rl - roff : bs;
        if (rblen != blen) continue;
        same = 1;
        for (k = 0; k < blen && same; k++)
          if (tgt_mem[toff+k] != base_mem[roff+k]) same = 0;
        if (!same) continue;
        found = 1;
        cb = tail_len(toff, roff);
        cf = lead_len(toff + blen, tl - toff - blen, roff + blen, rl - roff - blen);
        if (cb + cf >= best_b + best_f) begin
          best_b = cb;
          best_f = cf;
          best_off = roff;
        end
      end
      if (!found) continue;
      start = toff - best_b;
      if (unacc < start) begin
        push_instr(KIND_INSERT, unacc, start - unacc);
      end else begin
        back = unacc - start;
        while (back > 0 && ins_cnt > 0) begin
          i = ins_cnt - 1;
          sz = ins_len[i];
          take = (back < sz) ? back : sz;
          if (ins_kind[i] == KIND_COPY) saved = (saved >= take) ? saved - take : 0;
          if (sz <= back) ins_cnt--;
          else ins_len[i] = sz - back;
          back -= take;
        end
      end
      csize = best_b + blen + best_f;
      push_instr(KIND_COPY, best_off - best_b, csize);
      saved += csize;
      unacc = toff + blen + best_f;
    end
    end_start = tl - suf;
    if (unacc > end_start) end_start = unacc;
    end_len = tl - end_start;
    if (unacc < end_start) push_instr(KIND_INSERT, unacc, end_start - unacc);
    if (end_len != 0) push_instr(KIND_COPY, rl - end_len, end_len);
    sav_total = (saved > SAVINGS_MAX) ? SAVINGS_MAX : int'(saved);
    rd_ptr = 0;
  endfunction

  function automatic resp_t encoder_step(logic [FUNC_W-1:0] f, logic [7:0] b);
    resp_t r;
    r = '0;
    case (f)
      FN_CLEAR: begin
        tgt_len = 0;
        base_len = 0;
        ins_cnt = 0;
        rd_ptr = 0;
        sav_total = 0;
      end
      FN_APP_T: begin
        if (tgt_len < CHUNK) begin
          tgt_mem[tgt_len] = b;
          tgt_len++;
        end else r.status = ST_FULL;
      end
      FN_APP_R: begin
        if (base_len < CHUNK) begin
          base_mem[base_len] = b;
          base_len++;
        end else r.status = ST_FULL;
      end
      FN_ENCODE: run_encode();
      FN_READ: begin
        if (rd_ptr < ins_cnt) begin
          r.kind   = ins_kind[rd_ptr];
          r.offset = OFF_W'(ins_off[rd_ptr]);
          r.length = LEN_W'(ins_len[rd_ptr]);
          r.last   = (rd_ptr + 1 == ins_cnt);
          rd_ptr++;
        end else r.status = ST_EMPTY;
      end
      default: ;
    endcase
    r.total   = TOTAL_W'(ins_cnt);
    r.savings = SAV_W'(sav_total);
    return r;
  endfunction

  task automatic send_word(logic [FUNC_W-1:0] f, logic [7:0] b, bit typed, resp_t want);
    int gap;
    resp_t w;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    func      <= f;
    data_byte <= b;
    do @(posedge clk_i); while (!in_ready);
    w = encoder_step(f, b);
    pending_words.push_back(typed ? want : w);
    n_sent++;
    if (f == FN_ENCODE) n_encodes++;
    if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
  endtask

  task automatic send(logic [FUNC_W-1:0] f, logic [7:0] b);
    send_word(f, b, 1'b0, '0);
  endtask

  task automatic set_block_size(logic [BS_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    blk_size_reg = v;
  endtask

  task automatic drain_reads(int extra);
    int n;
    n = ins_cnt - rd_ptr + extra;
    repeat (n) send(FN_READ, 8'($urandom));
  endtask

  // one clear/load/encode/readback pass; reference is mostly an edited target
  task automatic random_case();
    logic [7:0] tq [$];
    logic [7:0] rq [$];
    int tl, rl, edits, pos, run, ti, ri;
    logic [7:0] v;
    send(FN_CLEAR, 8'($urandom));
    tl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(8, 110);
    repeat (tl) tq.push_back(8'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      rl = $urandom_range(0, 110);
      repeat (rl) rq.push_back(8'($urandom));
    end else begin
      rq = tq;
      edits = $urandom_range(0, 4);
      repeat (edits) begin
        pos = (rq.size() == 0) ? 0 : $urandom_range(0, rq.size() - 1);
        case ($urandom_range(0, 2))
          0: if (rq.size() != 0) rq[pos] = 8'($urandom);
          1: begin
            run = $urandom_range(1, 20);
            repeat (run) rq.insert(pos, 8'($urandom));
          end
          default: begin
            run = $urandom_range(1, 20);
            repeat (run) if (pos < rq.size()) rq.delete(pos);
          end
        endcase
      end
    end
    ti = 0;
    ri = 0;
    while (ti < tq.size() || ri < rq.size()) begin
      if (ri >= rq.size() || (ti < tq.size() && $urandom_range(0, 1))) begin
        send(FN_APP_T, tq[ti]);
        ti++;
      end else begin
        send(FN_APP_R, rq[ri]);
        ri++;
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      v = 8'($urandom);
      send(3'($urandom_range(0, 7)), v);
    end
    send(FN_ENCODE, 8'($urandom));
    drain_reads($urandom_range(0, 2));
  endtask

  dir_row_t dir_tab [13];
  initial begin
    dir_tab = '{
      '{FN_READ,     8'h00, 1'b1, '{ST_EMPTY, 1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}},
      '{FN_SPARE_LO, 8'hff, 1'b1, '{ST_OK,    1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}},
      '{FN_SPARE_HI, 8'h5a, 1'b1, '{ST_OK,    1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}},
      '{FN_ENCODE,   8'h00, 1'b1, '{ST_OK,    1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}},
      '{FN_READ,     8'hff, 1'b1, '{ST_EMPTY, 1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}},
      '{FN_APP_T,    8'h00, 1'b1, '{ST_OK,    1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}},
      '{FN_APP_T,    8'hff, 1'b1, '{ST_OK,    1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}},
      '{FN_APP_R,    8'h00, 1'b1, '{ST_OK,    1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}},
      '{FN_APP_R,    8'hff, 1'b1, '{ST_OK,    1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}},
      '{FN_ENCODE,   8'h00, 1'b0, '0},
      '{FN_READ,     8'h00, 1'b0, '0},
      '{FN_READ,     8'h00, 1'b0, '0},
      '{FN_CLEAR,    8'hff, 1'b1, '{ST_OK,    1'b0, 12'd0, 13'd0, 11'd0, 14'd0, 1'b0}}
    };
  end

  initial begin
    int n_case;
    tgt_len = 0;
    base_len = 0;
    ins_cnt = 0;
    rd_ptr = 0;
    sav_total = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_word(dir_tab[i].func, dir_tab[i].data, dir_tab[i].typed,
                                   dir_tab[i].want);

    n_case = 0;
    while (n_sent < RAND_WORDS) begin
      if (n_case % 5 == 0) begin
        case ($urandom_range(0, 7))
          0: set_block_size(13'd0);
          1: set_block_size(13'd15);
          2: set_block_size(BS_W'(BLOCK_MIN));
          3: set_block_size(13'd4096);
          4: set_block_size(13'h1fff);
          5: set_block_size(13'($urandom));
          default: set_block_size(13'($urandom_range(16, 40)));
        endcase
      end
      random_case();
      n_case++;
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d words, checked %0d responses over %0d encodes (%0d random passes).",
             n_sent, n_checked, n_encodes, n_case);
    $display("Mismatches: %0d", err_cnt);
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
    end
  end

  task automatic flag_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    resp_t w;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("unexpected word", 0, 0);
      end else begin
        w = pending_words.pop_front();
        n_checked++;
        if (status !== w.status) flag_mismatch("status", status, w.status);
        if (instr_kind !== w.kind) flag_mismatch("instr_kind", instr_kind, w.kind);
        if (instr_offset !== w.offset) flag_mismatch("instr_offset", instr_offset, w.offset);
        if (instr_length !== w.length) flag_mismatch("instr_length", instr_length, w.length);
        if (instr_total !== w.total) flag_mismatch("instr_total", instr_total, w.total);
        if (est_savings !== w.savings) flag_mismatch("est_savings", est_savings, w.savings);
        if (last !== w.last) flag_mismatch("last", last, w.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

endmodule

@@ fixed_block_delta_encoder.f @@
hw/rtl/fbde_pkg.sv
hw/rtl/fbde_ram.sv
hw/rtl/fbde_match.sv
hw/rtl/fbde_datapath.sv
hw/rtl/fbde_ctrl.sv
hw/rtl/fixed_block_delta_encoder.sv
hw/rtl/fbde_checker.sv
tb/sv/tb_fixed_block_delta_encoder.sv
